@@ src/fhlm_pkg.sv @@
// fhlm_pkg: shared types, codes and default sizes for the FIFO handoff lock manager.
// Used by the channel interfaces and by fifo_handoff_lock_manager_unit. No dependencies.
package fhlm_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TASK_ID_BITS_DEF = 8;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] status_t;

  // request kinds
  localparam kind_t KIND_LOCK    = 2'd0;
  localparam kind_t KIND_TRY     = 2'd1;
  localparam kind_t KIND_RELEASE = 2'd2;

  // result status codes
  localparam status_t ST_GRANTED   = 3'd0;
  localparam status_t ST_QUEUED    = 3'd1;
  localparam status_t ST_DENIED    = 3'd2;
  localparam status_t ST_RELEASED  = 3'd3;
  localparam status_t ST_GAVE_UP   = 3'd4;
  localparam status_t ST_NOT_FOUND = 3'd5;
  localparam status_t ST_FULL      = 3'd6;
  localparam status_t ST_RECURSIVE = 3'd7;

endpackage

@@ src/fhlm_if.sv @@
// fhlm_if: valid/ready channel interfaces for lock requests and lock results.
// Depends on fhlm_pkg for the kind and status types and default sizes.
interface fhlm_in_if #(
  parameter int TASK_ID_BITS = fhlm_pkg::TASK_ID_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  fhlm_pkg::kind_t         kind;
  logic [TASK_ID_BITS-1:0] task_id;

  modport source (output valid, output kind, output task_id, input ready);
  modport sink   (input valid, input kind, input task_id, output ready);
endinterface

interface fhlm_out_if #(
  parameter int TASK_ID_BITS = fhlm_pkg::TASK_ID_BITS_DEF,
  parameter int QUEUE_DEPTH  = fhlm_pkg::QUEUE_DEPTH_DEF
);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic                    valid;
  logic                    ready;
  fhlm_pkg::status_t       status;
  logic                    wake_valid;
  logic [TASK_ID_BITS-1:0] wake_task;
  logic                    owner_valid;
  logic [TASK_ID_BITS-1:0] owner_task;
  logic [CNTW-1:0]         waiting_count;

  modport source (output valid, output status, output wake_valid, output wake_task,
                  output owner_valid, output owner_task, output waiting_count,
                  input ready);
  modport sink   (input valid, input status, input wake_valid, input wake_task,
                  input owner_valid, input owner_task, input waiting_count,
                  output ready);
endinterface

@@ src/fifo_handoff_lock_manager_unit.sv @@
// fifo_handoff_lock_manager_unit: one lock with an owner and a FIFO of waiting task ids.
// Depends on fhlm_pkg and on the fhlm_in_if / fhlm_out_if channel interfaces.
//
// Usage:
//   in_ch  carries one request per transaction: kind (lock, try, release/give up) and task_id.
//   out_ch returns exactly one result transaction per request: status, woken waiter,
//          owner after the request and the number of waiters left.
// Sequencing:
//   Lock, try, plain release and unused kinds: the sequencer goes from idle to the result
//   state, which loads the output register once the slot is free, and then back to idle.
//   A release that hands off, and a give up, walk the waiter memory through its single
//   registered read port before the result state, and the next request follows once the
//   sequencer is back in idle. The walk reads one entry per cycle and shifts later entries
//   down one slot behind the match.
//   in_ch.ready is high only while the sequencer is idle; one request is in work
//   at a time.
// Reset (rst_n low, synchronous): lock free, owner 0, queue empty, no result pending.
//   The waiter memory is not cleared; only entries below the count are ever read.
// Stall: the result waits in the output register while out_ch.ready is low; a new
//   request may be taken meanwhile, and its result waits until the slot frees.
module fifo_handoff_lock_manager_unit #(
  parameter int QUEUE_DEPTH  = fhlm_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = fhlm_pkg::TASK_ID_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fhlm_in_if.sink    in_ch,
  fhlm_out_if.source out_ch
);
  import fhlm_pkg::*;

  localparam int QIW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int TIDW = TASK_ID_BITS;

  localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(QUEUE_DEPTH);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]      state_r, state_nxt;

  // lock state
  logic            held_r, held_nxt;
  logic [TIDW-1:0] holder_r, holder_nxt;
  logic [CNTW-1:0] total_r, total_nxt;

  // waiter memory, oldest at entry 0
  logic [TIDW-1:0] wq_mem [QUEUE_DEPTH];
  logic            wr_en;
  logic [QIW-1:0]  wr_addr;
  logic [TIDW-1:0] wr_data;
  logic            rd_en;
  logic [QIW-1:0]  rd_addr;
  logic [TIDW-1:0] rd_data_r;

  // walk control
  logic [TIDW-1:0] tid_r, tid_nxt;
  logic            pop_r, pop_nxt;       // handoff walk: entry 0 is the match
  logic            found_r, found_nxt;   // match seen, shifting later entries down
  logic [CNTW-1:0] iss_r, iss_nxt;       // next entry to read
  logic            pend_r, pend_nxt;     // read data valid this cycle
  logic [QIW-1:0]  pidx_r, pidx_nxt;     // entry that rd_data_r came from
  logic [TIDW-1:0] wake_r, wake_nxt;
  logic            match;

  // pending result
  status_t         res_status_r, res_status_nxt;
  logic            res_wake_v_r, res_wake_v_nxt;
  logic [TIDW-1:0] res_wake_t_r, res_wake_t_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic            out_wake_v_r, out_wake_v_nxt;
  logic [TIDW-1:0] out_wake_t_r, out_wake_t_nxt;
  logic            out_own_v_r, out_own_v_nxt;
  logic [TIDW-1:0] out_own_t_r, out_own_t_nxt;
  logic [CNTW-1:0] out_cnt_r, out_cnt_nxt;

  logic            in_fire;
  logic            slot_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign match = pop_r ? (pidx_r == '0) : (rd_data_r == tid_r);

  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    holder_nxt     = holder_r;
    total_nxt      = total_r;
    tid_nxt        = tid_r;
    pop_nxt        = pop_r;
    found_nxt      = found_r;
    iss_nxt        = iss_r;
    pend_nxt       = 1'b0;
    pidx_nxt       = pidx_r;
    wake_nxt       = wake_r;
    res_status_nxt = res_status_r;
    res_wake_v_nxt = res_wake_v_r;
    res_wake_t_nxt = res_wake_t_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_wake_v_nxt = out_wake_v_r;
    out_wake_t_nxt = out_wake_t_r;
    out_own_v_nxt  = out_own_v_r;
    out_own_t_nxt  = out_own_t_r;
    out_cnt_nxt    = out_cnt_r;
    wr_en          = 1'b0;
    wr_addr        = total_r[QIW-1:0];
    wr_data        = in_ch.task_id;
    rd_en          = 1'b0;
    rd_addr        = iss_r[QIW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          tid_nxt        = in_ch.task_id;
          res_wake_v_nxt = 1'b0;
          res_wake_t_nxt = '0;
          res_status_nxt = ST_DENIED;
          state_nxt      = S_RESP;
          case (in_ch.kind)
            KIND_LOCK: begin
              if (!held_r) begin
                held_nxt       = 1'b1;
                holder_nxt     = in_ch.task_id;
                res_status_nxt = ST_GRANTED;
              end else if (holder_r == in_ch.task_id) begin
                res_status_nxt = ST_RECURSIVE;
              end else if (total_r >= DEPTH_CNT) begin
                res_status_nxt = ST_FULL;
              end else begin
                // join the tail
                wr_en          = 1'b1;
                total_nxt      = total_r + 1'b1;
                res_status_nxt = ST_QUEUED;
              end
            end
            KIND_TRY: begin
              if (!held_r) begin
                held_nxt       = 1'b1;
                holder_nxt     = in_ch.task_id;
                res_status_nxt = ST_GRANTED;
              end
            end
            KIND_RELEASE: begin
              if (held_r && holder_r == in_ch.task_id && total_r == '0) begin
                held_nxt       = 1'b0;
                holder_nxt     = '0;
                res_status_nxt = ST_RELEASED;
              end else begin
                // handoff to oldest waiter, or give up: both walk the queue
                pop_nxt   = held_r && holder_r == in_ch.task_id;
                found_nxt = 1'b0;
                iss_nxt   = '0;
                state_nxt = S_WALK;
              end
            end
            default: begin
              res_status_nxt = ST_DENIED;
            end
          endcase
        end
      end

      S_WALK: begin
        // issue one read per cycle
        if (iss_r < total_r) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = iss_r[QIW-1:0];
          iss_nxt  = iss_r + 1'b1;
        end
        // handle data read last cycle
        if (pend_r) begin
          if (found_r) begin
            wr_en   = 1'b1;
            wr_addr = pidx_r - 1'b1;
            wr_data = rd_data_r;
          end else if (match) begin
            found_nxt = 1'b1;
            wake_nxt  = rd_data_r;
          end
        end
        if (!rd_en && !pend_r) begin
          state_nxt = S_RESP;
          if (pop_r) begin
            holder_nxt     = wake_r;
            total_nxt      = total_r - 1'b1;
            res_status_nxt = ST_RELEASED;
            res_wake_v_nxt = 1'b1;
            res_wake_t_nxt = wake_r;
          end else if (found_r) begin
            total_nxt      = total_r - 1'b1;
            res_status_nxt = ST_GAVE_UP;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_wake_v_nxt = res_wake_v_r;
          out_wake_t_nxt = res_wake_t_r;
          out_own_v_nxt  = held_r;
          out_own_t_nxt  = held_r ? holder_r : '0;
          out_cnt_nxt    = total_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // waiter memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wq_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= wq_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= 1'b0;
      holder_r    <= '0;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      holder_r    <= holder_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tid_r        <= tid_nxt;
    pop_r        <= pop_nxt;
    found_r      <= found_nxt;
    iss_r        <= iss_nxt;
    pidx_r       <= pidx_nxt;
    wake_r       <= wake_nxt;
    res_status_r <= res_status_nxt;
    res_wake_v_r <= res_wake_v_nxt;
    res_wake_t_r <= res_wake_t_nxt;
    out_status_r <= out_status_nxt;
    out_wake_v_r <= out_wake_v_nxt;
    out_wake_t_r <= out_wake_t_nxt;
    out_own_v_r  <= out_own_v_nxt;
    out_own_t_r  <= out_own_t_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.wake_valid    = out_wake_v_r;
  assign out_ch.wake_task     = out_wake_t_r;
  assign out_ch.owner_valid   = out_own_v_r;
  assign out_ch.owner_task    = out_own_t_r;
  assign out_ch.waiting_count = out_cnt_r;

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for fifo_handoff_lock_manager_unit (one lock, FIFO of waiters).
// Depends on fhlm_pkg, the fhlm_in_if / fhlm_out_if channels and the lock manager RTL.
// Directed checks of every request kind and corner, then random traffic in three idling phases.
module tb_top;
  import fhlm_pkg::*;

  // Kind code 3 has no name in the package; the block treats it as a denied no-op.
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam int    QDEPTH      = QUEUE_DEPTH_DEF;

  // One result transaction, packed; the checker compares it field by field with !==, which also catches X/Z.
  typedef struct packed {
    status_t    status;
    logic       wake_valid;
    logic [7:0] wake_task;
    logic       owner_valid;
    logic [7:0] owner_task;
    logic [4:0] waiting_count;
  } lock_result_t;

  logic clk = 1'b0;
  logic rst_n;

  fhlm_in_if  in_ch ();
  fhlm_out_if out_ch ();

  fifo_handoff_lock_manager_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the lock: owner flag, owner id and the waiter FIFO (oldest first).
  logic         lock_held;
  logic [7:0]   lock_owner;
  logic [7:0]   waiters[$];

  lock_result_t expected_results[$];
  lock_result_t seen_result;
  lock_result_t want_result;
  int unsigned  mismatch_count;

  // Idle percentages for each side, changed per phase.
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  // Small pool of task ids so that requests collide and the queue really fills.
  logic [7:0]   id_pool[6];

  always #2 clk = ~clk;

  // Receiver side: ready drops at random according to the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Work out the result of one accepted request and advance the shadow lock.
  function automatic lock_result_t predict_lock(kind_t kind, logic [7:0] tid);
    lock_result_t r;
    int           hit;
    r = '0;
    r.status = ST_DENIED;
    hit = -1;
    case (kind)
      KIND_LOCK: begin
        if (!lock_held) begin
          lock_held  = 1'b1;
          lock_owner = tid;
          r.status   = ST_GRANTED;
        end else if (lock_owner == tid) begin
          r.status = ST_RECURSIVE;
        end else if (waiters.size() >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          waiters.insert(waiters.size(), tid);
          r.status = ST_QUEUED;
        end
      end
      KIND_TRY: begin
        if (!lock_held) begin
          lock_held  = 1'b1;
          lock_owner = tid;
          r.status   = ST_GRANTED;
        end
      end
      KIND_RELEASE: begin
        if (lock_held && lock_owner == tid) begin
          // owner release: hand straight to the oldest waiter, or free the lock
          if (waiters.size() != 0) begin
            lock_owner   = waiters[0];
            waiters.delete(0);
            r.wake_valid = 1'b1;
            r.wake_task  = lock_owner;
          end else begin
            lock_held  = 1'b0;
            lock_owner = '0;
          end
          r.status = ST_RELEASED;
        end else begin
          // give up: only the oldest entry with this id leaves, order kept
          foreach (waiters[i]) begin
            if (hit < 0 && waiters[i] == tid) hit = i;
          end
          if (hit >= 0) begin
            waiters.delete(hit);
            r.status = ST_GAVE_UP;
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
      end
      default: ;
    endcase
    r.owner_valid   = lock_held;
    r.owner_task    = lock_held ? lock_owner : 8'h00;
    r.waiting_count = 5'(waiters.size());
    return r;
  endfunction

  function automatic string fmt_result(lock_result_t r);
    return $sformatf("status=%0d wake=%0b/%02h owner=%0b/%02h waiting=%0d",
                     r.status, r.wake_valid, r.wake_task, r.owner_valid, r.owner_task,
                     r.waiting_count);
  endfunction

  // Result checker: every accepted result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_result.status        = out_ch.status;
      seen_result.wake_valid    = out_ch.wake_valid;
      seen_result.wake_task     = out_ch.wake_task;
      seen_result.owner_valid   = out_ch.owner_valid;
      seen_result.owner_task    = out_ch.owner_task;
      seen_result.waiting_count = out_ch.waiting_count;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction: %s", fmt_result(seen_result));
      end else begin
        want_result = expected_results[0];
        expected_results.delete(0);
        if (seen_result.status        !== want_result.status     ||
            seen_result.wake_valid    !== want_result.wake_valid ||
            seen_result.wake_task     !== want_result.wake_task  ||
            seen_result.owner_valid   !== want_result.owner_valid ||
            seen_result.owner_task    !== want_result.owner_task ||
            seen_result.waiting_count !== want_result.waiting_count) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %s", fmt_result(want_result));
            $display("          actual   %s", fmt_result(seen_result));
          end
        end
      end
    end
  end

  // Send one request transaction. Valid only drops during a random gap, so
  // back-to-back requests keep it high without a second assignment in one step.
  task automatic send_request(kind_t kind, logic [7:0] tid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.task_id <= tid;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.insert(expected_results.size(), predict_lock(kind, tid));
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic refresh_id_pool();
    foreach (id_pool[i]) id_pool[i] = 8'($urandom_range(255));
  endtask

  function automatic logic [7:0] pick_id();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return id_pool[$urandom_range(5)];
  endfunction

  // One random request. Releases mostly come from the owner (hand-off) or a
  // queued waiter (give up); a few percent are noise, kind 3 included.
  task automatic random_request(int unsigned lock_pct);
    int unsigned r;
    kind_t       kind;
    logic [7:0]  tid;
    r = $urandom_range(99);
    if (r < lock_pct) begin
      kind = KIND_LOCK;
      tid  = pick_id();
    end else if (r < lock_pct + 12) begin
      kind = KIND_TRY;
      tid  = pick_id();
    end else if (r < 96) begin
      kind = KIND_RELEASE;
      r    = $urandom_range(9);
      if (r < 6 && lock_held)
        tid = lock_owner;
      else if (r < 9 && waiters.size() != 0)
        tid = waiters[$urandom_range(waiters.size() - 1)];
      else
        tid = pick_id();
    end else begin
      kind = kind_t'($urandom_range(3));
      tid  = 8'($urandom_range(255));
    end
    send_request(kind, tid);
  endtask

  // Every kind, both id extremes, and the corners: release of a free lock,
  // unused kind, try by the owner, recursive lock, duplicate waiter, full
  // queue, give up from the middle and from the head, unknown give up, hand-off.
  task automatic test_directed();
    send_request(KIND_RELEASE, 8'h07);   // free lock: not found
    send_request(KIND_UNUSED,  8'hF8);   // denied, no change
    send_request(KIND_TRY,     8'h00);   // granted
    send_request(KIND_LOCK,    8'h00);   // recursive
    send_request(KIND_TRY,     8'h00);   // owner try: denied
    send_request(KIND_TRY,     8'hFF);   // held: denied
    send_request(KIND_LOCK,    8'hFF);
    for (int i = 1; i < QDEPTH - 1; i++) send_request(KIND_LOCK, 8'(i));
    send_request(KIND_LOCK,    8'hFF);   // duplicate waiter fills the queue
    send_request(KIND_LOCK,    8'hAA);   // queue full
    send_request(KIND_RELEASE, 8'h07);   // give up from the middle
    send_request(KIND_RELEASE, 8'hFF);   // oldest duplicate leaves
    send_request(KIND_RELEASE, 8'h33);   // not queued
    send_request(KIND_RELEASE, 8'h00);   // hand-off to waiter 01
  endtask

  // Balanced lock/try/release traffic; the sender waits for a full drain now and then.
  task automatic test_handoff_traffic(int n);
    refresh_id_pool();
    for (int i = 0; i < n; i++) begin
      random_request(40);
      if ($urandom_range(99) == 0) wait_all_results();
    end
  endtask

  // Alternating lock-heavy and release-heavy bursts to hit the full queue and drain it.
  task automatic test_queue_saturation(int n);
    refresh_id_pool();
    for (int i = 0; i < n; i++) random_request(((i / 30) % 2 == 0) ? 80 : 15);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_LOCK;
    in_ch.task_id    = '0;
    lock_held        = 1'b0;
    lock_owner       = '0;
    mismatch_count   = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender idles rarely, receiver stalls a lot
    set_idling(22, 81);
    test_directed();
    test_handoff_traffic(400);
    test_queue_saturation(140);
    wait_all_results();

    // phase 2: the other way round
    set_idling(81, 22);
    test_handoff_traffic(400);
    test_queue_saturation(140);
    wait_all_results();

    // phase 3: no idling on either side
    set_idling(0, 0);
    test_handoff_traffic(400);
    test_queue_saturation(140);

    wait_all_results();
    repeat (25) @(posedge clk);
    mismatch_count += expected_results.size();
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
